[rtl/core/jsh_pkg.sv]
// Shared types, codes and defaults of the joint state histogram.
package jsh_pkg;

  localparam int NUM_VARS_DEF    = 4;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int COUNT_WIDTH_DEF = 16;

  // Variables that have input fields and size registers.
  localparam int FIELD_VARS = 4;
  // Sizes stay below 16, so any index of four variables fits in 16 bits.
  localparam int IDX_W   = 16;
  localparam int VAL_W   = 4;
  localparam int RIDX_W  = 12;
  localparam int CNT_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_COUNT = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_D = 2'd3;

  typedef logic [VAL_W-1:0] nib_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             bad;
  } idx_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_DONE
  } jsh_state_t;

endpackage

[rtl/core/jsh_index.sv]
// Mixed-radix index unit: stride registers and the index and range check of one sample.
module jsh_index import jsh_pkg::*; #(
  parameter int NUM_VARS    = NUM_VARS_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic     clk,
  input  nib_t     sizes [FIELD_VARS],
  input  nib_t     vals  [FIELD_VARS],
  output idx_res_t res
);

  localparam logic [IDX_W:0] DEPTH_L = (IDX_W+1)'(TABLE_DEPTH);

  logic [IDX_W-1:0] stride [FIELD_VARS];

  // One multiply per stride stage; each stage builds on the registered stride before it.
  always_ff @(posedge clk) begin
    stride[0] <= IDX_W'(1);
    for (int i = 1; i < FIELD_VARS; i++) begin
      stride[i] <= IDX_W'(stride[i-1] * sizes[i-1]);
    end
  end

  always_comb begin
    logic [IDX_W-1:0] acc;
    logic             bad;
    nib_t             dig;
    acc = '0;
    bad = 1'b0;
    for (int i = 0; i < FIELD_VARS; i++) begin
      dig = vals[i] - nib_t'(1);
      if (i < NUM_VARS) begin
        if (vals[i] == '0 || vals[i] > sizes[i]) begin
          bad = 1'b1;
        end else begin
          acc = acc + IDX_W'(dig * stride[i]);
        end
      end
    end
    if ({1'b0, acc} >= DEPTH_L) begin
      bad = 1'b1;
    end
    res.index = acc;
    res.bad   = bad;
  end

endmodule

[rtl/core/jsh_table.sv]
// Counter table: one write port and one registered read port.
module jsh_table import jsh_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [COUNT_WIDTH-1:0] rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [COUNT_WIDTH-1:0] wr_data
);

  logic [COUNT_WIDTH-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/joint_state_histogram.sv]
// Top level of the joint state histogram: control sequencer, size registers, output register.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   func, val_a..val_d, read_index
//   out      output     out_valid / out_ready table_index, count_value, range_error
//   cfg      input      cfg_en                cfg_index, cfg_data
//
// A count, read or unused func runs these steps from acceptance to the next acceptance:
// stage the item, read the counter memory, modify and write back, load the output register.
// A clear sweeps the memory one entry a cycle.
// After reset a clearing pass over the whole table runs before in_ready rises.
// After a size write in_ready stays low while the stride registers settle.
// A result that is not taken holds the block in its last step; the input side is taken
// again as soon as the result sits in the output register.
module joint_state_histogram import jsh_pkg::*; #(
  parameter int NUM_VARS    = NUM_VARS_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [VAL_W-1:0]     val_a,
  input  logic [VAL_W-1:0]     val_b,
  input  logic [VAL_W-1:0]     val_c,
  input  logic [VAL_W-1:0]     val_d,
  input  logic [RIDX_W-1:0]    read_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RIDX_W-1:0]    table_index,
  output logic [CNT_W-1:0]     count_value,
  output logic                 range_error,
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0] DEPTH_L = (IDX_W+1)'(TABLE_DEPTH);
  localparam int SW = $clog2(FIELD_VARS);
  localparam logic [SW-1:0] SETTLE_CYCLES = SW'(FIELD_VARS - 1);

  jsh_state_t state, state_next;

  nib_t sizes [FIELD_VARS];
  nib_t vals  [FIELD_VARS];
  logic [SW-1:0] settle;

  logic [1:0]        it_func;
  logic [RIDX_W-1:0] it_ri;

  logic [1:0]        lk_func;
  logic [AW-1:0]     lk_addr;
  logic [RIDX_W-1:0] lk_index;
  logic              lk_err;

  logic [AW-1:0]     clr_addr;
  logic              clr_report;

  logic [RIDX_W-1:0] res_index;
  logic [CNT_W-1:0]  res_count;
  logic              res_err;

  idx_res_t               ix;
  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_addr;
  logic [COUNT_WIDTH-1:0] mem_rd_data;
  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [COUNT_WIDTH-1:0] mem_wr_data;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH+CNT_W-1:0] cnt_ext;
  logic [COUNT_WIDTH+CNT_W-1:0] rd_ext;

  logic in_fire;
  logic out_load;
  logic clr_last;
  logic ri_ok;

  assign in_fire  = in_valid && in_ready;
  assign clr_last = (clr_addr == LAST_ADDR);
  assign ri_ok    = ({(IDX_W-RIDX_W+1)'(0), it_ri} < DEPTH_L);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sizes[0] <= nib_t'(2);
      sizes[1] <= nib_t'(2);
      sizes[2] <= nib_t'(2);
      sizes[3] <= nib_t'(1);
      settle   <= SETTLE_CYCLES;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_SIZE_A: sizes[0] <= cfg_data;
        REG_SIZE_B: sizes[1] <= cfg_data;
        REG_SIZE_C: sizes[2] <= cfg_data;
        REG_SIZE_D: sizes[3] <= cfg_data;
        default: ;
      endcase
      settle <= SETTLE_CYCLES;
    end else if (settle != '0) begin
      settle <= settle - SW'(1);
    end
  end

  jsh_index #(
    .NUM_VARS    (NUM_VARS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_index (
    .clk   (clk),
    .sizes (sizes),
    .vals  (vals),
    .res   (ix)
  );

  jsh_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_table (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = clr_report ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (func == FUNC_CLEAR) ? ST_CLEAR : ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready    = 1'b0;
    out_load    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ix.index[AW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_addr;
    mem_wr_data = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready = (settle == '0);
      end
      ST_LOOKUP: begin
        if (it_func == FUNC_COUNT) begin
          mem_rd_en   = !ix.bad;
          mem_rd_addr = ix.index[AW-1:0];
        end else if (it_func == FUNC_READ) begin
          mem_rd_en   = ri_ok;
          mem_rd_addr = AW'({(IDX_W-RIDX_W)'(0), it_ri});
        end
      end
      ST_UPDATE: begin
        mem_wr_en   = (lk_func == FUNC_COUNT) && !lk_err;
        mem_wr_addr = lk_addr;
        mem_wr_data = cnt_inc;
      end
      ST_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  // Saturating increment; the result field carries the low bits of the counter.
  assign cnt_inc = (&mem_rd_data) ? mem_rd_data : mem_rd_data + COUNT_WIDTH'(1);
  assign cnt_ext = {CNT_W'(0), cnt_inc};
  assign rd_ext  = {CNT_W'(0), mem_rd_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + AW'(1);
      end
      if (in_fire) begin
        clr_report <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_func <= func;
      vals[0] <= val_a;
      vals[1] <= val_b;
      vals[2] <= val_c;
      vals[3] <= val_d;
      it_ri   <= read_index;
    end
    if (state == ST_LOOKUP) begin
      lk_func <= it_func;
      lk_addr <= ix.index[AW-1:0];
      case (it_func)
        FUNC_COUNT: begin
          lk_index <= ix.index[RIDX_W-1:0];
          lk_err   <= ix.bad;
        end
        FUNC_READ: begin
          lk_index <= it_ri;
          lk_err   <= !ri_ok;
        end
        default: begin
          lk_index <= '0;
          lk_err   <= 1'b0;
        end
      endcase
    end
    if (state == ST_UPDATE) begin
      res_index <= lk_index;
      res_err   <= lk_err;
      case (lk_func)
        FUNC_COUNT: res_count <= lk_err ? '0 : cnt_ext[CNT_W-1:0];
        FUNC_READ:  res_count <= lk_err ? '0 : rd_ext[CNT_W-1:0];
        default:    res_count <= '0;
      endcase
    end
    if (state == ST_CLEAR && clr_last) begin
      res_index <= '0;
      res_count <= '0;
      res_err   <= 1'b0;
    end
    if (out_load) begin
      table_index <= res_index;
      count_value <= res_count;
      range_error <= res_err;
    end
  end

endmodule
